// ----- rtl/kast_pkg.sv -----
package kast_pkg;

    localparam int DEF_ENTRIES  = 256;
    localparam int DEF_MAX_CPUS = 256;

    localparam int CPU_W  = 8;
    localparam int REG_W  = 32;
    localparam int DUR_W  = 32;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 32;
    localparam int TOT_W  = 64;
    localparam int STAT_W = 3;

    typedef enum logic [0:0] {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_UPDATED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_READ_VALID = 3'd3,
        ST_READ_EMPTY = 3'd4
    } t_status;

    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic [REG_W-1:0] reg_num;
        logic [CNT_W-1:0] count;
        logic [TOT_W-1:0] total;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- rtl/keyed_access_stats_table_unit.sv -----
// Per-key access statistics table. A record transaction (cmd 0) looks up the key
// {cpu_id, reg_num} among the filled entries; a hit bumps the count and adds the
// duration to the 64-bit total, a miss fills the next free entry, and a full table
// or a cpu_id at or above MAX_CPUS drops the record with status 2. A read
// transaction (cmd 1) returns entry entry_index, or status 4 if it is not filled.
// Entries fill in index order and are never removed, so a fill counter marks the
// valid ones and no clearing pass runs after reset. All entries live in one
// single-port-write memory with a registered read, and the lookup compares one
// entry per cycle from index zero up to a hit or the fill level, also for a
// record then dropped on a full table. A record dropped for its cpu_id, a record
// into an empty table and a read of an unfilled entry load their result straight
// from the idle state; a read of a filled entry passes through the read state.
// The next transaction is accepted only once the result leaves the output
// register, at the earliest at the edge that hands that result over.
module keyed_access_stats_table_unit
    import kast_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int MAX_CPUS = DEF_MAX_CPUS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [0:0]        i_cmd,
    input  logic [CPU_W-1:0]  i_cpu_id,
    input  logic [REG_W-1:0]  i_reg_num,
    input  logic [DUR_W-1:0]  i_duration,
    input  logic [IDX_W-1:0]  i_entry_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [CPU_W-1:0]  o_entry_cpu,
    output logic [REG_W-1:0]  o_entry_reg,
    output logic [CNT_W-1:0]  o_entry_count,
    output logic [TOT_W-1:0]  o_entry_total
);

    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW     = $clog2(ENTRIES + 1);
    localparam int IXCW   = FW + IDX_W;
    localparam int CPUCW  = $clog2(MAX_CPUS + 1) + CPU_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_READ   = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CPU_W-1:0]  r_cpu, n_cpu;
    logic [REG_W-1:0]  r_reg, n_reg;
    logic [DUR_W-1:0]  r_dur, n_dur;
    logic [AW-1:0]     r_addr, n_addr;
    logic [FW-1:0]     r_fill, n_fill;

    logic              r_o_valid;
    t_status           r_status, n_status;
    logic [CPU_W-1:0]  r_ecpu, n_ecpu;
    logic [REG_W-1:0]  r_ereg, n_ereg;
    logic [CNT_W-1:0]  r_ecnt, n_ecnt;
    logic [TOT_W-1:0]  r_etot, n_etot;

    logic              load_out;
    logic              out_free;
    logic              in_accept;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    t_entry            ram_wdata;
    t_entry            rd_entry;
    logic [FW-1:0]     next_addr;
    logic              idx_hit;
    logic              cpu_bad;
    logic              tbl_full;

    kast_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    assign out_free  = !r_o_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE) && out_free;
    assign in_accept = i_valid && o_ready;

    assign idx_hit   = IXCW'(i_entry_index) < IXCW'(r_fill);
    assign cpu_bad   = CPUCW'(i_cpu_id) >= CPUCW'(MAX_CPUS);
    assign tbl_full  = r_fill == FW'(ENTRIES);
    assign next_addr = FW'(r_addr) + FW'(1);

    always_comb begin
        n_state   = r_state;
        n_cpu     = r_cpu;
        n_reg     = r_reg;
        n_dur     = r_dur;
        n_addr    = r_addr;
        n_fill    = r_fill;
        load_out  = 1'b0;
        n_status  = r_status;
        n_ecpu    = r_ecpu;
        n_ereg    = r_ereg;
        n_ecnt    = r_ecnt;
        n_etot    = r_etot;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_raddr = r_addr;
        ram_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cpu = i_cpu_id;
                    n_reg = i_reg_num;
                    n_dur = i_duration;
                    if (i_cmd == CMD_READ) begin
                        if (idx_hit) begin
                            ram_raddr = AW'(i_entry_index);
                            n_state   = S_READ;
                        end else begin
                            load_out = 1'b1;
                            n_status = ST_READ_EMPTY;
                            n_ecpu   = '0;
                            n_ereg   = '0;
                            n_ecnt   = '0;
                            n_etot   = '0;
                        end
                    end else if (cpu_bad) begin
                        load_out = 1'b1;
                        n_status = ST_DROPPED;
                        n_ecpu   = i_cpu_id;
                        n_ereg   = i_reg_num;
                        n_ecnt   = '0;
                        n_etot   = '0;
                    end else if (r_fill == '0) begin
                        // empty table: fill entry zero right away
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = '{cpu: i_cpu_id, reg_num: i_reg_num,
                                      count: CNT_W'(1), total: TOT_W'(i_duration)};
                        n_fill    = r_fill + FW'(1);
                        load_out  = 1'b1;
                        n_status  = ST_INSERTED;
                        n_ecpu    = i_cpu_id;
                        n_ereg    = i_reg_num;
                        n_ecnt    = CNT_W'(1);
                        n_etot    = TOT_W'(i_duration);
                    end else begin
                        ram_raddr = '0;
                        n_addr    = '0;
                        n_state   = S_SEARCH;
                    end
                end
            end

            S_SEARCH: begin
                // rd_entry holds the entry at r_addr
                if (rd_entry.cpu == r_cpu && rd_entry.reg_num == r_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_addr;
                    ram_wdata = '{cpu: r_cpu, reg_num: r_reg,
                                  count: rd_entry.count + CNT_W'(1),
                                  total: rd_entry.total + TOT_W'(r_dur)};
                    load_out  = 1'b1;
                    n_status  = ST_UPDATED;
                    n_ecpu    = r_cpu;
                    n_ereg    = r_reg;
                    n_ecnt    = ram_wdata.count;
                    n_etot    = ram_wdata.total;
                    n_state   = S_IDLE;
                end else if (next_addr != r_fill) begin
                    // advance the scan, one read per cycle
                    n_addr    = AW'(next_addr);
                    ram_raddr = AW'(next_addr);
                end else if (tbl_full) begin
                    load_out = 1'b1;
                    n_status = ST_DROPPED;
                    n_ecpu   = r_cpu;
                    n_ereg   = r_reg;
                    n_ecnt   = '0;
                    n_etot   = '0;
                    n_state  = S_IDLE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_fill);
                    ram_wdata = '{cpu: r_cpu, reg_num: r_reg,
                                  count: CNT_W'(1), total: TOT_W'(r_dur)};
                    n_fill    = r_fill + FW'(1);
                    load_out  = 1'b1;
                    n_status  = ST_INSERTED;
                    n_ecpu    = r_cpu;
                    n_ereg    = r_reg;
                    n_ecnt    = CNT_W'(1);
                    n_etot    = TOT_W'(r_dur);
                    n_state   = S_IDLE;
                end
            end

            S_READ: begin
                load_out = 1'b1;
                n_status = ST_READ_VALID;
                n_ecpu   = rd_entry.cpu;
                n_ereg   = rd_entry.reg_num;
                n_ecnt   = rd_entry.count;
                n_etot   = rd_entry.total;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpu  <= n_cpu;
        r_reg  <= n_reg;
        r_dur  <= n_dur;
        r_addr <= n_addr;
        if (load_out) begin
            r_status <= n_status;
            r_ecpu   <= n_ecpu;
            r_ereg   <= n_ereg;
            r_ecnt   <= n_ecnt;
            r_etot   <= n_etot;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_entry_cpu   = r_ecpu;
    assign o_entry_reg   = r_ereg;
    assign o_entry_count = r_ecnt;
    assign o_entry_total = r_etot;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(ENTRIES))
        else $error("fill level beyond table size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result loaded over a pending transaction");

    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_o_valid)
        else $error("result pending while a transaction is in flight");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (FW'(ram_waddr) <= r_fill) && !tbl_full || (FW'(ram_waddr) < r_fill))
        else $error("memory write outside the filled region");

    a_insert_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_status == ST_INSERTED) |=> r_fill == $past(r_fill) + FW'(1))
        else $error("insert did not advance the fill level");

endmodule

// ----- rtl/kast_ram.sv -----
module kast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- verif/access_stats_checker.sv -----
`timescale 1ns / 100ps

module access_stats_checker
    import kast_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [0:0]        i_cmd,
    input  logic [CPU_W-1:0]  i_cpu_id,
    input  logic [REG_W-1:0]  i_reg_num,
    input  logic [DUR_W-1:0]  i_duration,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [STAT_W-1:0] i_status,
    input  logic [CPU_W-1:0]  i_entry_cpu,
    input  logic [REG_W-1:0]  i_entry_reg,
    input  logic [CNT_W-1:0]  i_entry_count,
    input  logic [TOT_W-1:0]  i_entry_total,
    output int                o_mismatches,
    output int                o_results_owed
);

    typedef struct packed {
        t_status status;
        t_entry  entry;
    } t_access_result;

    t_entry         stats_shadow [DEF_ENTRIES];
    int             slots_filled = 0;
    t_access_result predicted_stats [$];
    int             mismatches = 0;

    // Entries fill in index order and never leave, so the first slots_filled are valid.
    function automatic t_access_result apply_access(t_cmd cmd, logic [CPU_W-1:0] cpu,
            logic [REG_W-1:0] regn, logic [DUR_W-1:0] dur, logic [IDX_W-1:0] idx);
        t_access_result res;
        res.status = ST_DROPPED;
        res.entry  = '{cpu: cpu, reg_num: regn, count: '0, total: '0};
        if (cmd == CMD_READ) begin
            if (int'(idx) < DEF_ENTRIES && int'(idx) < slots_filled) begin
                res.status = ST_READ_VALID;
                res.entry  = stats_shadow[idx];
            end else begin
                res.status = ST_READ_EMPTY;
                res.entry  = '0;
            end
            return res;
        end
        if (int'(cpu) >= DEF_MAX_CPUS)
            return res;
        for (int i = 0; i < slots_filled; i++) begin
            if (stats_shadow[i].cpu == cpu && stats_shadow[i].reg_num == regn) begin
                stats_shadow[i].count = stats_shadow[i].count + 1'b1;
                stats_shadow[i].total = stats_shadow[i].total + TOT_W'(dur);
                res.status = ST_UPDATED;
                res.entry  = stats_shadow[i];
                return res;
            end
        end
        // table full: drop, nothing changes
        if (slots_filled >= DEF_ENTRIES)
            return res;
        stats_shadow[slots_filled] = '{cpu: cpu, reg_num: regn, count: CNT_W'(1),
                                       total: TOT_W'(dur)};
        res.status = ST_INSERTED;
        res.entry  = stats_shadow[slots_filled];
        slots_filled++;
        return res;
    endfunction

    task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_access_result want;
        if (!i_rst_n) begin
            slots_filled = 0;
            predicted_stats.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predicted_stats.push_back(apply_access(t_cmd'(i_cmd), i_cpu_id, i_reg_num,
                                                       i_duration, i_entry_index));
            if (i_out_valid && i_out_ready) begin
                if (predicted_stats.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none, actual status %0d",
                             $time, i_status);
                end else begin
                    want = predicted_stats.pop_front();
                    compare_field("status", 64'(want.status), 64'(i_status));
                    compare_field("entry_cpu", 64'(want.entry.cpu), 64'(i_entry_cpu));
                    compare_field("entry_reg", 64'(want.entry.reg_num), 64'(i_entry_reg));
                    compare_field("entry_count", 64'(want.entry.count), 64'(i_entry_count));
                    compare_field("entry_total", want.entry.total, i_entry_total);
                end
            end
        end
        o_results_owed <= predicted_stats.size();
        o_mismatches   <= mismatches;
    end

endmodule

// ----- verif/keyed_access_stats_table_unit_test.sv -----
`timescale 1ns / 100ps

module keyed_access_stats_table_unit_test;
    import kast_pkg::*;

    localparam int KEY_W         = CPU_W + REG_W;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = DEF_ENTRIES + 40;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [0:0]        i_cmd;
    logic [CPU_W-1:0]  i_cpu_id;
    logic [REG_W-1:0]  i_reg_num;
    logic [DUR_W-1:0]  i_duration;
    logic [IDX_W-1:0]  i_entry_index;
    logic              o_valid;
    logic              i_ready;
    logic [STAT_W-1:0] o_status;
    logic [CPU_W-1:0]  o_entry_cpu;
    logic [REG_W-1:0]  o_entry_reg;
    logic [CNT_W-1:0]  o_entry_count;
    logic [TOT_W-1:0]  o_entry_total;

    int               mismatch_count;
    int               results_owed;
    logic [KEY_W-1:0] known_keys [$];
    bit               calm_tx = 1'b0;
    bit               calm_rx = 1'b0;

    keyed_access_stats_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_cpu_id      (i_cpu_id),
        .i_reg_num     (i_reg_num),
        .i_duration    (i_duration),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_cpu   (o_entry_cpu),
        .o_entry_reg   (o_entry_reg),
        .o_entry_count (o_entry_count),
        .o_entry_total (o_entry_total)
    );

    access_stats_checker stats_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_cmd          (i_cmd),
        .i_cpu_id       (i_cpu_id),
        .i_reg_num      (i_reg_num),
        .i_duration     (i_duration),
        .i_entry_index  (i_entry_index),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_status       (o_status),
        .i_entry_cpu    (o_entry_cpu),
        .i_entry_reg    (o_entry_reg),
        .i_entry_count  (o_entry_count),
        .i_entry_total  (o_entry_total),
        .o_mismatches   (mismatch_count),
        .o_results_owed (results_owed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // stop a hung run
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, with calm stretches
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = calm_rx ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic push_item(t_cmd cmd, logic [CPU_W-1:0] cpu, logic [REG_W-1:0] regn,
            logic [DUR_W-1:0] dur, logic [IDX_W-1:0] idx);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_cpu_id      <= cpu;
        i_reg_num     <= regn;
        i_duration    <= dur;
        i_entry_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Track distinct keys in table order so hits and near misses can be aimed.
    task automatic record_access(logic [KEY_W-1:0] key, logic [DUR_W-1:0] dur);
        bit seen;
        seen = 1'b0;
        foreach (known_keys[k])
            if (known_keys[k] == key) seen = 1'b1;
        if (!seen && known_keys.size() < DEF_ENTRIES)
            known_keys.push_back(key);
        push_item(CMD_RECORD, key[KEY_W-1:REG_W], key[REG_W-1:0], dur, IDX_W'($urandom));
    endtask

    task automatic read_slot(logic [IDX_W-1:0] idx);
        push_item(CMD_READ, CPU_W'($urandom), $urandom, $urandom, idx);
    endtask

    // Hold the sender until every outstanding transaction has returned.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
    endtask

    initial begin
        int               choice;
        logic [KEY_W-1:0] key;
        logic [DUR_W-1:0] dur;
        logic [IDX_W-1:0] idx;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cmd         <= CMD_RECORD;
        i_cpu_id      <= '0;
        i_reg_num     <= '0;
        i_duration    <= '0;
        i_entry_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes of key and duration, near-miss keys, ignored fields
        read_slot(IDX_W'(0));
        push_item(CMD_READ, '1, '1, '1, '1);
        record_access({8'h00, 32'h0000_0000}, 32'h0000_0000);
        record_access({8'h00, 32'h0000_0000}, 32'hFFFF_FFFF);
        record_access({8'h00, 32'h0000_0000}, 32'hFFFF_FFFF);
        record_access({8'hFF, 32'hFFFF_FFFF}, 32'hFFFF_FFFF);
        record_access({8'h00, 32'hFFFF_FFFF}, 32'h0000_0001);
        record_access({8'hFF, 32'h0000_0000}, 32'h0000_0001);
        record_access({8'hFF, 32'hFFFF_FFFF}, 32'h0000_0000);
        record_access({8'h80, 32'h8000_0000}, 32'h8000_0000);
        for (int s = 0; s < 6; s++)
            read_slot(IDX_W'(s));
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                calm_tx = ($urandom_range(0, 3) == 0);
                calm_rx <= ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            choice = $urandom_range(0, 99);
            if (choice < 15) begin
                // aim half the reads at the filled region and its first free slot
                if ($urandom_range(0, 1) == 1)
                    idx = IDX_W'($urandom_range(0, known_keys.size()));
                else
                    idx = IDX_W'($urandom);
                read_slot(idx);
            end else begin
                if (choice < 50 && known_keys.size() > 0)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (choice < 60 && known_keys.size() > 0)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)]
                          ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
                else
                    key = {CPU_W'($urandom), REG_W'($urandom)};
                case ($urandom_range(0, 9))
                    0:       dur = '0;
                    1:       dur = '1;
                    default: dur = $urandom;
                endcase
                record_access(key, dur);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
